// File: design/xlz_pkg.sv
package xlz_pkg;

    // Command kinds handed from the front end to the back end.
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_LIT   = 2'd1;
    localparam logic [1:0] CMD_MATCH = 2'd2;

    // Result error codes.
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_TRUNC  = 2'd1;
    localparam logic [1:0] ERR_OFFSET = 2'd2;

    // Configuration register indexes.
    localparam logic REG_KEY_EVEN = 1'b0;
    localparam logic REG_KEY_ODD  = 1'b1;

    localparam logic [7:0] KEY_EVEN_RESET = 8'd66;
    localparam logic [7:0] KEY_ODD_RESET  = 8'd83;

    // Tokens governed by one flag byte; this value also means "expecting a flag byte".
    localparam logic [3:0] FLAG_TOKENS = 4'd8;

    // Command queue between the front and back ends.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;      // literal byte or match length
        logic [15:0] offset;    // match back offset
        logic        is_start;  // first byte of an entry: restart the write pointer
        logic        is_end;    // last byte of an entry
        logic [1:0]  err;
    } t_cmd;

endpackage

// File: design/xlz_front.sv
module xlz_front #(
    parameter int WINDOW_SIZE = 4096
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_packed_byte,
    input  logic            i_entry_start,
    input  logic            i_entry_end,
    input  logic            i_cfg_we,
    input  logic            i_cfg_index,
    input  logic [7:0]      i_cfg_data,
    output xlz_pkg::t_cmd   o_cmd
);

    localparam int BHW = $clog2(WINDOW_SIZE + 1);
    localparam int CW  = (BHW + 1 > 17) ? BHW + 1 : 17;
    localparam logic [BHW-1:0] BH_MAX = BHW'(WINDOW_SIZE);

    logic [7:0]     r_key_even, r_key_odd;
    logic [7:0]     r_flags,  n_flags;
    logic [3:0]     r_tidx,   n_tidx;
    logic [1:0]     r_tphase, n_tphase;
    logic [15:0]    r_off,    n_off;
    logic           r_kphase, n_kphase;
    logic [BHW-1:0] r_held,   n_held;

    logic [7:0]     clear_byte;
    logic [CW-1:0]  held_sum;
    logic           bad_offset;

    always_comb begin
        n_flags  = r_flags;
        n_tidx   = r_tidx;
        n_tphase = r_tphase;
        n_off    = r_off;
        n_kphase = r_kphase;
        n_held   = r_held;
        if (i_entry_start) begin
            n_flags  = '0;
            n_tidx   = xlz_pkg::FLAG_TOKENS;
            n_tphase = '0;
            n_off    = '0;
            n_kphase = 1'b0;
            n_held   = '0;
        end

        clear_byte = i_packed_byte ^ (n_kphase ? r_key_odd : r_key_even);
        n_kphase   = ~n_kphase;
        held_sum   = CW'(n_held) + CW'(clear_byte);
        bad_offset = (n_off == 16'd0) || (CW'(n_off) > CW'(n_held));

        o_cmd          = '0;
        o_cmd.kind     = xlz_pkg::CMD_NONE;
        o_cmd.data     = clear_byte;
        o_cmd.offset   = n_off;
        o_cmd.is_start = i_entry_start;
        o_cmd.is_end   = i_entry_end;
        o_cmd.err      = xlz_pkg::ERR_NONE;

        if (n_tidx >= xlz_pkg::FLAG_TOKENS) begin
            n_flags = clear_byte;
            n_tidx  = '0;
        end else if (!n_flags[n_tidx[2:0]]) begin
            o_cmd.kind = xlz_pkg::CMD_LIT;
            if (n_held < BH_MAX) begin
                n_held = n_held + 1'b1;
            end
            n_tidx = n_tidx + 1'b1;
        end else if (n_tphase == 2'd0) begin
            n_off    = {8'd0, clear_byte};
            n_tphase = 2'd1;
        end else if (n_tphase == 2'd1) begin
            n_off    = {clear_byte, n_off[7:0]};
            n_tphase = 2'd2;
        end else begin
            n_tphase = 2'd0;
            if (bad_offset) begin
                o_cmd.err = xlz_pkg::ERR_OFFSET;
            end else begin
                o_cmd.kind = xlz_pkg::CMD_MATCH;
                if (held_sum > CW'(WINDOW_SIZE)) begin
                    n_held = BH_MAX;
                end else begin
                    n_held = held_sum[BHW-1:0];
                end
            end
            n_tidx = n_tidx + 1'b1;
        end

        if (i_entry_end) begin
            if (n_tphase != 2'd0) begin
                o_cmd.err = xlz_pkg::ERR_TRUNC;
            end
            n_flags  = '0;
            n_tidx   = xlz_pkg::FLAG_TOKENS;
            n_tphase = '0;
            n_off    = '0;
            n_kphase = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_even <= xlz_pkg::KEY_EVEN_RESET;
            r_key_odd  <= xlz_pkg::KEY_ODD_RESET;
            r_flags    <= '0;
            r_tidx     <= xlz_pkg::FLAG_TOKENS;
            r_tphase   <= '0;
            r_off      <= '0;
            r_kphase   <= 1'b0;
            r_held     <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == xlz_pkg::REG_KEY_EVEN) begin
                    r_key_even <= i_cfg_data;
                end else begin
                    r_key_odd <= i_cfg_data;
                end
            end
            if (i_accept) begin
                r_flags  <= n_flags;
                r_tidx   <= n_tidx;
                r_tphase <= n_tphase;
                r_off    <= n_off;
                r_kphase <= n_kphase;
                r_held   <= n_held;
            end
        end
    end

endmodule

// File: design/xlz_cmd_fifo.sv
module xlz_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  xlz_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output xlz_pkg::t_cmd o_data
);

    xlz_pkg::t_cmd                r_mem [xlz_pkg::QUEUE_DEPTH];
    logic [xlz_pkg::QPTR_W-1:0]   r_wr, r_rd;
    logic [xlz_pkg::QCNT_W-1:0]   r_count;

    assign o_full  = (r_count == xlz_pkg::QCNT_W'(xlz_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) !(i_pop && !o_valid))
        else $error("command queue popped while empty");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) !(i_push && o_full))
        else $error("command queue pushed while full");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("command queue count lost a push");

endmodule

// File: design/xlz_back.sv
module xlz_back #(
    parameter int WINDOW_SIZE = 4096,
    parameter int LANES       = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  xlz_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [63:0]   o_out_bytes,
    output logic [3:0]    o_byte_count,
    output logic          o_run_last,
    output logic          o_entry_done,
    output logic [1:0]    o_error_code
);

    localparam int AW    = $clog2(WINDOW_SIZE);
    localparam int CNT_W = $clog2(LANES + 1);
    localparam logic [AW-1:0] ADDR_LAST = AW'(WINDOW_SIZE - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_COPY  = 2'd1;
    localparam logic [1:0] ST_CLOSE = 2'd2;

    logic [7:0]           r_hist [WINDOW_SIZE];
    logic [7:0]           r_rdata;

    logic [1:0]           r_state;
    logic [AW-1:0]        r_wa, r_src;
    logic [7:0]           r_remain;
    logic                 r_rd_valid;
    logic                 r_lit_sel, r_byp, r_off1, r_first;
    logic [7:0]           r_lit, r_last;
    logic                 r_is_end;
    logic [1:0]           r_err;
    logic [LANES*8-1:0]   r_acc, n_acc;
    logic [CNT_W-1:0]     r_acc_cnt, n_acc_cnt;

    logic                 r_ov, r_o_last, r_o_done;
    logic [63:0]          r_o_data;
    logic [3:0]           r_o_cnt;
    logic [1:0]           r_o_err;

    logic                 out_free, acc_full, emit_go, issue, close_need, close_go;
    logic                 push_full, push_close;
    logic [7:0]           e_val;
    logic [AW-1:0]        base, start_src;
    logic [16:0]          diff;

    assign o_pop      = (r_state == ST_IDLE) && i_cmd_valid;
    assign out_free   = !r_ov || !i_out_stall;
    assign acc_full   = (r_acc_cnt == CNT_W'(LANES));
    assign e_val      = r_lit_sel ? r_lit : (r_byp ? r_last : r_rdata);
    assign emit_go    = (r_state == ST_COPY) && r_rd_valid && (!acc_full || out_free);
    assign issue      = (r_state == ST_COPY) && (r_remain != 8'd0) && (!r_rd_valid || emit_go);
    assign close_need = (r_acc_cnt != '0) || r_is_end || (r_err != xlz_pkg::ERR_NONE);
    assign close_go   = (r_state == ST_CLOSE) && (!close_need || out_free);
    assign push_full  = emit_go && acc_full;
    assign push_close = close_go && close_need;

    // Source of the first copied byte: write pointer minus the offset, around the window.
    always_comb begin
        base = i_cmd.is_start ? '0 : r_wa;
        diff = 17'(base) - 17'(i_cmd.offset);
        if (diff[16]) begin
            diff = diff + 17'(WINDOW_SIZE);
        end
        start_src = diff[AW-1:0];
    end

    // Packing of one decoded byte into the lane accumulator.
    always_comb begin
        n_acc     = r_acc;
        n_acc_cnt = r_acc_cnt;
        if (acc_full) begin
            n_acc       = '0;
            n_acc[7:0]  = e_val;
            n_acc_cnt   = CNT_W'(1);
        end else begin
            for (int l = 0; l < LANES; l++) begin
                if (r_acc_cnt == CNT_W'(l)) begin
                    n_acc[l*8 +: 8] = e_val;
                end
            end
            n_acc_cnt = r_acc_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            r_hist[r_wa] <= e_val;
        end
        if (issue) begin
            r_rdata <= r_hist[r_src];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_wa       <= '0;
            r_remain   <= '0;
            r_rd_valid <= 1'b0;
            r_acc      <= '0;
            r_acc_cnt  <= '0;
            r_ov       <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        r_wa      <= base;
                        r_src     <= start_src;
                        r_off1    <= (i_cmd.offset == 16'd1);
                        r_first   <= 1'b1;
                        r_lit     <= i_cmd.data;
                        r_is_end  <= i_cmd.is_end;
                        r_err     <= i_cmd.err;
                        r_lit_sel <= 1'b0;
                        if (i_cmd.kind == xlz_pkg::CMD_LIT) begin
                            r_lit_sel  <= 1'b1;
                            r_rd_valid <= 1'b1;
                            r_remain   <= '0;
                            r_state    <= ST_COPY;
                        end else if (i_cmd.kind == xlz_pkg::CMD_MATCH && i_cmd.data != 8'd0) begin
                            r_remain <= i_cmd.data;
                            r_state  <= ST_COPY;
                        end else begin
                            r_state <= ST_CLOSE;
                        end
                    end
                end
                ST_COPY: begin
                    if (issue) begin
                        r_src      <= (r_src == ADDR_LAST) ? '0 : r_src + 1'b1;
                        r_remain   <= r_remain - 1'b1;
                        // With an offset of one, every byte after the first repeats the
                        // byte written in the same cycle, which the memory cannot return yet.
                        r_byp      <= r_off1 && !r_first;
                        r_first    <= 1'b0;
                        r_lit_sel  <= 1'b0;
                        r_rd_valid <= 1'b1;
                    end else if (emit_go) begin
                        r_rd_valid <= 1'b0;
                    end
                    if (emit_go) begin
                        r_wa      <= (r_wa == ADDR_LAST) ? '0 : r_wa + 1'b1;
                        r_last    <= e_val;
                        r_acc     <= n_acc;
                        r_acc_cnt <= n_acc_cnt;
                    end
                    if (r_remain == 8'd0 && (!r_rd_valid || emit_go)) begin
                        r_state <= ST_CLOSE;
                    end
                end
                ST_CLOSE: begin
                    if (close_go) begin
                        r_state <= ST_IDLE;
                        if (close_need) begin
                            r_acc     <= '0;
                            r_acc_cnt <= '0;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            if (push_full || push_close) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_full) begin
            r_o_data <= 64'(r_acc);
            r_o_cnt  <= 4'(r_acc_cnt);
            r_o_last <= 1'b0;
            r_o_done <= 1'b0;
            r_o_err  <= xlz_pkg::ERR_NONE;
        end else if (push_close) begin
            r_o_data <= 64'(r_acc);
            r_o_cnt  <= 4'(r_acc_cnt);
            r_o_last <= 1'b1;
            r_o_done <= r_is_end;
            r_o_err  <= r_err;
        end
    end

    assign o_out_valid  = r_ov;
    assign o_out_bytes  = r_o_data;
    assign o_byte_count = r_o_cnt;
    assign o_run_last   = r_o_last;
    assign o_entry_done = r_o_done;
    assign o_error_code = r_o_err;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_o_cnt == 4'd0) |-> r_o_last)
        else $error("empty result that is not the last of its item");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_o_err != xlz_pkg::ERR_NONE) |-> (r_o_last && r_o_cnt == 4'd0))
        else $error("error reported on a result that carries bytes");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!r_rd_valid && r_remain == 8'd0))
        else $error("copy work left over when the back end went idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_full |-> !push_close)
        else $error("two results loaded into the output register at once");

endmodule

// File: design/xor_lz77_stream_decompressor_top.sv
// Descrambling LZSS decoder, one packed byte per input beat. Each byte is XORed with
// the even or odd key byte, alternating from the even key at the first byte of every
// entry, and then parsed as flag-byte groups of literals and three-byte matches
// (little-endian back offset, then length) against a WINDOW_SIZE-byte history.
// Decoded bytes leave up to LANES per result beat, first byte in the low bits, with
// run_last on the last result of each input beat and entry_done on the last result of
// an entry. The front end parses and descrambles one beat per cycle while the queue
// has room and queues a command for it; the back end executes commands one at a time
// from a four-deep queue. A match copies its bytes one per cycle unless the result
// channel stalls, as the history memory delivers them through its single registered
// read port. Input beats are taken without stalling until the command queue
// is full. A truncated match gives error_code 1 and an offset of zero or beyond the
// bytes held gives error_code 2, each on a single empty result. The history needs no
// clearing after reset: offsets are checked against the bytes written in the entry.
module xor_lz77_stream_decompressor_top #(
    parameter int WINDOW_SIZE = 4096,
    parameter int LANES       = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Packed byte input channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_packed_byte,
    input  logic        i_entry_start,
    input  logic        i_entry_end,

    // Decoded result channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_out_bytes,
    output logic [3:0]  o_byte_count,
    output logic        o_run_last,
    output logic        o_entry_done,
    output logic [1:0]  o_error_code,

    // Configuration write channel: index 0 is the even key, index 1 the odd key.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    xlz_pkg::t_cmd front_cmd, queue_cmd;
    logic          queue_full, queue_valid, queue_pop, in_accept;

    // Configuration writes are always taken; the keys live in the front end.
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = queue_full;
    assign in_accept   = i_in_valid && !queue_full;

    xlz_front #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_packed_byte (i_packed_byte),
        .i_entry_start (i_entry_start),
        .i_entry_end   (i_entry_end),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_cmd         (front_cmd)
    );

    xlz_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_data  (front_cmd),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_data  (queue_cmd)
    );

    xlz_back #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .LANES       (LANES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (queue_valid),
        .i_cmd        (queue_cmd),
        .o_pop        (queue_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_bytes  (o_out_bytes),
        .o_byte_count (o_byte_count),
        .o_run_last   (o_run_last),
        .o_entry_done (o_entry_done),
        .o_error_code (o_error_code)
    );

    // A beat is never accepted while the queue is full.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) queue_full |-> !in_accept)
        else $error("input beat accepted into a full command queue");
    // The result count never exceeds the lane count.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_byte_count <= 4'(LANES)))
        else $error("result carries more bytes than lanes");
    // An entry_done result is always the last one of its input beat.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_entry_done) |-> o_run_last)
        else $error("entry_done on a result that is not the last of its beat");

endmodule
